@@ src/periodic_timer_bank_assert.svh @@
// Assertion macros for the periodic timer bank.
// Each expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef PERIODIC_TIMER_BANK_ASSERT_SVH
`define PERIODIC_TIMER_BANK_ASSERT_SVH

// Same-cycle implication.
`define PTB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ptb_pkg.sv @@
package ptb_pkg;

    localparam int SLOTS       = 16;
    localparam int PERIOD_BITS = 16;

    localparam int POS_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int ID_W       = 5;
    localparam int MODE_W     = 2;
    localparam int KIND_W     = 2;
    localparam int INTERVAL_W = 16;
    localparam int MAXT_W     = 5;

    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_DEL  = 2'd2
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_EXPIRY = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_DEL    = 2'd2
    } t_kind;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                   shift;
        logic [MODE_W-1:0]      mode;
        logic [PERIOD_BITS-1:0] period;
        logic                   add_ok;
        logic                   del_ok;
        logic [POS_W-1:0]       del_pos;
    } t_ctl;

    // Handed from one cell to the next.
    typedef struct packed {
        logic tok;
        logic taken;
    } t_link;

    function automatic logic [PERIOD_BITS-1:0] sat_period(input logic [INTERVAL_W-1:0] iv);
        logic [32:0] ext;
        ext = 33'(iv);
        if (ext > 33'(PERIOD_MAX)) begin
            return PERIOD_MAX;
        end
        return PERIOD_BITS'(ext);
    endfunction

endpackage

@@ src/ptb_cell.sv @@
module ptb_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [ptb_pkg::POS_W-1:0] i_idx,
    input  ptb_pkg::t_ctl             i_ctl,
    input  ptb_pkg::t_link            i_link,
    output ptb_pkg::t_link            o_link,
    output logic                      o_hit
);

    logic                            r_tok;
    logic                            r_taken;
    logic                            r_active;
    logic [ptb_pkg::PERIOD_BITS-1:0] r_period;
    logic [ptb_pkg::PERIOD_BITS-1:0] r_elapsed;

    logic                            n_active;
    logic [ptb_pkg::PERIOD_BITS-1:0] n_period;
    logic [ptb_pkg::PERIOD_BITS-1:0] n_elapsed;
    logic                            w_act;
    logic                            w_grab;
    logic [ptb_pkg::PERIOD_BITS:0]   w_inc;

    assign w_act = r_tok & i_ctl.shift;
    assign w_inc = {1'b0, r_elapsed} + 1'b1;

    always_comb begin
        n_active  = r_active;
        n_period  = r_period;
        n_elapsed = r_elapsed;
        w_grab    = 1'b0;
        o_hit     = 1'b0;
        if (w_act) begin
            case (i_ctl.mode)
                ptb_pkg::MODE_TICK: begin
                    if (r_active) begin
                        if (w_inc >= {1'b0, r_period}) begin
                            n_elapsed = '0;
                            o_hit     = 1'b1;
                        end else begin
                            n_elapsed = ptb_pkg::PERIOD_BITS'(w_inc);
                        end
                    end
                end
                ptb_pkg::MODE_ADD: begin
                    // claim only if no lower slot has been claimed already
                    if (i_ctl.add_ok && !r_active && !r_taken) begin
                        n_active  = 1'b1;
                        n_period  = i_ctl.period;
                        n_elapsed = '0;
                        w_grab    = 1'b1;
                        o_hit     = 1'b1;
                    end
                end
                ptb_pkg::MODE_DEL: begin
                    if (i_ctl.del_ok && (i_ctl.del_pos == i_idx) && r_active) begin
                        n_active = 1'b0;
                        o_hit    = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_link.tok   = r_tok;
    assign o_link.taken = r_taken | w_grab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= 1'b0;
            r_taken  <= 1'b0;
            r_active <= 1'b0;
        end else begin
            if (i_ctl.shift) begin
                r_tok   <= i_link.tok;
                r_taken <= i_link.taken;
            end
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_period  <= n_period;
        r_elapsed <= n_elapsed;
    end

endmodule

@@ src/periodic_timer_bank.sv @@
// Periodic timer bank: SLOTS timer cells in a chain, one slot visited per cycle while
// the result side is free. Every item (tick, add, delete, unused mode) walks the
// chain: accept, SLOTS steps, one flush step; a new item is taken only after the flush.
// Add and delete answers enter the output register in the flush step.
// Reset is synchronous: all slots free, active count zero, capacity 16; no clearing pass.
module periodic_timer_bank (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // interval[15:0], del_id[20:16], zero pad
    input  logic [1:0]  i_s_axis_tuser,  // mode[1:0]
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // result_id[4:0], ok[5], zero pad
    output logic [1:0]  o_m_axis_tuser,  // kind[1:0]
    output logic        o_m_axis_tlast,
    // configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    localparam int SLOTS = ptb_pkg::SLOTS;
    localparam int POS_W = ptb_pkg::POS_W;
    localparam int CNT_W = ptb_pkg::CNT_W;
    localparam int ID_W  = ptb_pkg::ID_W;

    // ------------------------------------------------------------------
    // Control and payload registers
    // ------------------------------------------------------------------
    t_state                          r_state, n_state;
    logic [ptb_pkg::MODE_W-1:0]      r_mode;
    logic [ptb_pkg::PERIOD_BITS-1:0] r_period;
    logic                            r_add_ok;
    logic                            r_del_ok;
    logic [POS_W-1:0]                r_del_pos;
    logic [POS_W-1:0]                r_pos;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [ptb_pkg::MAXT_W-1:0]      r_max;

    // held expiry / answer, waiting to learn whether it is the last one
    logic                            r_hold_v, n_hold_v;
    logic [ptb_pkg::KIND_W-1:0]      r_hold_kind, n_hold_kind;
    logic [ID_W-1:0]                 r_hold_id, n_hold_id;

    // output register
    logic                            r_out_v, n_out_v;
    logic [ptb_pkg::KIND_W-1:0]      r_out_kind, n_out_kind;
    logic [ID_W-1:0]                 r_out_id, n_out_id;
    logic                            r_out_ok, n_out_ok;
    logic                            r_out_last, n_out_last;

    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_step;
    logic                            w_end;
    logic                            w_hit;
    logic [ID_W-1:0]                 w_id;
    logic [ptb_pkg::KIND_W-1:0]      w_kind;
    logic [6:0]                      w_cap;
    logic [6:0]                      w_tid_m1;
    logic [ptb_pkg::INTERVAL_W-1:0]  w_interval;
    logic [ID_W-1:0]                 w_tid;
    logic                            w_cfg_wr;

    ptb_pkg::t_ctl                   w_ctl;
    ptb_pkg::t_link                  w_link [SLOTS+1];
    logic [SLOTS-1:0]                w_hit_vec;
    logic [SLOTS-1:0]                w_tok_vec;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid & o_s_axis_tready;
    assign w_out_free      = !r_out_v || i_m_axis_tready;
    // advance the walk only when a result could be pushed on
    assign w_step          = (r_state == S_WALK) && w_out_free;
    // the last cell holds the token: this step finishes the walk
    assign w_end           = w_link[SLOTS].tok;

    assign w_interval = i_s_axis_tdata[15:0];
    assign w_tid      = i_s_axis_tdata[20:16];

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite && o_pready && !i_paddr[2];
    assign o_prdata = i_paddr[2] ? 32'd0 : 32'(r_max);

    // capacity clamps to the number of slots
    assign w_cap    = (7'(r_max) > 7'(SLOTS)) ? 7'(SLOTS) : 7'(r_max);
    assign w_tid_m1 = 7'(w_tid) - 7'd1;

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    assign w_ctl.shift   = w_accept | w_step;
    assign w_ctl.mode    = r_mode;
    assign w_ctl.period  = r_period;
    assign w_ctl.add_ok  = r_add_ok;
    assign w_ctl.del_ok  = r_del_ok;
    assign w_ctl.del_pos = r_del_pos;

    // inject the token at the head on each transfer
    assign w_link[0].tok   = w_accept;
    assign w_link[0].taken = 1'b0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ptb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (POS_W'(g)),
            .i_ctl   (w_ctl),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_hit   (w_hit_vec[g])
        );
        assign w_tok_vec[g] = w_link[g+1].tok;
    end

    // only the token holder can report, so a plain OR picks it
    assign w_hit = |w_hit_vec;
    assign w_id  = ID_W'(7'(r_pos) + 7'd1);

    always_comb begin
        case (r_mode)
            ptb_pkg::MODE_ADD: w_kind = ptb_pkg::KIND_ADD;
            ptb_pkg::MODE_DEL: w_kind = ptb_pkg::KIND_DEL;
            default:           w_kind = ptb_pkg::KIND_EXPIRY;
        endcase
    end

    // ------------------------------------------------------------------
    // Next state: walk sequencing, held report, output register, count
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_hold_v    = r_hold_v;
        n_hold_kind = r_hold_kind;
        n_hold_id   = r_hold_id;
        n_out_v     = r_out_v;
        n_out_kind  = r_out_kind;
        n_out_id    = r_out_id;
        n_out_ok    = r_out_ok;
        n_out_last  = r_out_last;

        if (r_out_v && i_m_axis_tready) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_step) begin
                    if (w_hit) begin
                        // a newer report exists, so the held one is not last
                        if (r_hold_v) begin
                            n_out_v    = 1'b1;
                            n_out_kind = r_hold_kind;
                            n_out_id   = r_hold_id;
                            n_out_ok   = 1'b1;
                            n_out_last = 1'b0;
                        end
                        n_hold_v    = 1'b1;
                        n_hold_kind = w_kind;
                        n_hold_id   = w_id;
                        if (r_mode == ptb_pkg::MODE_ADD) begin
                            n_count = r_count + 1'b1;
                        end else if (r_mode == ptb_pkg::MODE_DEL && r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                    if (w_end) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                    if (r_hold_v) begin
                        n_out_v    = 1'b1;
                        n_out_kind = r_hold_kind;
                        n_out_id   = r_hold_id;
                        n_out_ok   = 1'b1;
                        n_out_last = 1'b1;
                        n_hold_v   = 1'b0;
                    end else if (r_mode == ptb_pkg::MODE_ADD ||
                                 r_mode == ptb_pkg::MODE_DEL) begin
                        // add or delete found nothing: answer with a failure
                        n_out_v    = 1'b1;
                        n_out_kind = w_kind;
                        n_out_id   = '0;
                        n_out_ok   = 1'b0;
                        n_out_last = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_max    <= ptb_pkg::MAXT_W'(16);
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
            if (w_cfg_wr) begin
                r_max <= i_pwdata[ptb_pkg::MAXT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_kind <= n_hold_kind;
        r_hold_id   <= n_hold_id;
        r_out_kind  <= n_out_kind;
        r_out_id    <= n_out_id;
        r_out_ok    <= n_out_ok;
        r_out_last  <= n_out_last;
        if (w_accept) begin
            // latch the command for the whole walk
            r_mode    <= i_s_axis_tuser;
            r_period  <= ptb_pkg::sat_period(w_interval);
            r_add_ok  <= (w_interval != '0) && (7'(r_count) < w_cap);
            r_del_ok  <= (w_tid != '0) && (7'(w_tid) <= 7'(SLOTS));
            r_del_pos <= POS_W'(w_tid_m1);
            r_pos     <= '0;
        end else if (w_step) begin
            r_pos <= r_pos + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result port
    // ------------------------------------------------------------------
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {2'b00, r_out_ok, r_out_id};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `include "periodic_timer_bank_assert.svh"

    `PTB_ASSERT_NOW(a_one_token, 1'b1, $onehot0(w_tok_vec), "more than one token in the chain")
    `PTB_ASSERT_NOW(a_one_hit, 1'b1, $onehot0(w_hit_vec), "more than one cell reported")
    `PTB_ASSERT_NOW(a_add_claims, w_step && w_end && r_mode == ptb_pkg::MODE_ADD && r_add_ok,
                    w_link[SLOTS].taken, "admitted add found no free slot")
    `PTB_ASSERT_NEXT(a_walk_starts, w_accept, r_state == S_WALK && w_link[1].tok,
                     "transfer did not start a walk")

endmodule
